>>> src/nbi_pkg.sv
// ----------------------------------------------------------------------------
// nbi_pkg: shared constants and types
// Widths, register indexes and the controller to datapath command bundle
// for the backward-difference interpolator.
// ----------------------------------------------------------------------------
package nbi_pkg;

  localparam int POINTS_DEF = 5;
  localparam int KW         = 4;   // holds a difference order up to fifteen
  localparam int XW         = 32;  // Q16.16 word
  localparam int HW         = 31;  // spacing width
  localparam int NUMW       = 40;  // x minus last abscissa
  localparam int DVW        = 52;  // divider dividend width
  localparam int CIW        = 2;   // config index width

  localparam logic [CIW-1:0] REG_FIRST   = 2'd0;
  localparam logic [CIW-1:0] REG_SPACING = 2'd1;

  localparam logic [XW-1:0] FIRST_RST   = 32'd655360;
  localparam logic [HW-1:0] SPACING_RST = 31'd655360;
  localparam logic [HW-1:0] ONE_Q       = 31'd65536;
  localparam logic [HW-1:0] C_MAX       = {HW{1'b1}};
  localparam logic signed [62:0] ACC_MAX = 63'sd2305843009213693952;

  typedef struct packed {
    logic          load_wr;
    logic          query_go;
    logic          calc_num;
    logic          div_start;
    logic          div_coef;
    logic          take_s;
    logic          diff;
    logic          mul_c;
    logic          take_c;
    logic          mul_hi;
    logic          mul_lo;
    logic          acc_step;
    logic          fin;
    logic [KW-1:0] k;
  } nbi_cmd_t;

  typedef struct packed {
    logic div_done;
  } nbi_stat_t;

endpackage

>>> src/newton_backward_interpolator.sv
// ----------------------------------------------------------------------------
// newton_backward_interpolator: Newton backward-difference interpolator
// Q16.16 interpolation through a table of equally spaced samples.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers on a rising edge with start high and busy low.
//   mode 0 writes sample_value to table position sample_index (positions
//   of POINTS or more are dropped); it gives no result and busy stays low.
//   mode 1 queries at query_x; busy rises until the result is ready, then
//   interpolated and overflow are shown for one cycle with done high.
//   Config writes (cfg_index 0 first abscissa, 1 spacing) transfer on
//   cfg_valid with cfg_ready, which is always high; write only when idle.
//   After a query transfers, busy stays high through a sequence in which
//   the bit-serial divider (DVW = 52 steps) runs once for s and once per
//   difference order for the coefficient; done follows in the next cycle.
//   The done cycle is also the first cycle in which a new item transfers.
//   Reset clears the sample table to zero and loads both registers with
//   10.0; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module newton_backward_interpolator #(
  parameter int POINTS = nbi_pkg::POINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode,
  input  logic [2:0]              sample_index,
  input  logic signed [31:0]      sample_value,
  input  logic signed [31:0]      query_x,
  output logic                    done,
  output logic signed [31:0]      interpolated,
  output logic                    overflow,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [nbi_pkg::CIW-1:0] cfg_index,
  input  logic [31:0]             cfg_data
);

  nbi_pkg::nbi_cmd_t  cmd;
  nbi_pkg::nbi_stat_t stat;

  assign cfg_ready = 1'b1;

  nbi_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  nbi_dp #(.POINTS(POINTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .query_x      (query_x),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .interpolated (interpolated),
    .overflow     (overflow)
  );

endmodule

>>> src/nbi_div.sv
// ----------------------------------------------------------------------------
// nbi_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module nbi_div #(
  parameter int DVW = nbi_pkg::DVW,
  parameter int DSW = nbi_pkg::HW
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] q;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [CW-1:0]  cnt;
  logic [DSW:0]   trial;
  logic [DSW:0]   trial_sub;
  logic           fits;

  assign trial     = {rem, q[DVW-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};
  assign quotient  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q   <= dividend;
        rem <= '0;
        dsr <= divisor;
        cnt <= CW'(DVW);
      end else if (cnt != '0) begin
        rem <= fits ? trial_sub[DSW-1:0] : trial[DSW-1:0];
        q   <= {q[DVW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/nbi_ctrl.sv
// ----------------------------------------------------------------------------
// nbi_ctrl: interpolator sequencer
// Steps the datapath through divide, difference, multiply and sum phases.
// ----------------------------------------------------------------------------
module nbi_ctrl #(
  parameter int POINTS = nbi_pkg::POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  nbi_pkg::nbi_stat_t stat,
  output nbi_pkg::nbi_cmd_t  cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_NUM    = 12'b000000000010,
    S_SSTART = 12'b000000000100,
    S_SWAIT  = 12'b000000001000,
    S_DIFF   = 12'b000000010000,
    S_MULC   = 12'b000000100000,
    S_CSTART = 12'b000001000000,
    S_CWAIT  = 12'b000010000000,
    S_MULH   = 12'b000100000000,
    S_MULL   = 12'b001000000000,
    S_ACC    = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  state_t                    state, state_next;
  logic [nbi_pkg::KW-1:0]    k, k_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    cmd.k      = k;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (mode) begin
            cmd.query_go = 1'b1;
            k_next       = nbi_pkg::KW'(1);
            state_next   = S_NUM;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_NUM: begin
        cmd.calc_num = 1'b1;
        state_next   = S_SSTART;
      end
      S_SSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_SWAIT;
      end
      S_SWAIT: begin
        if (stat.div_done) begin
          cmd.take_s = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MULC;
      end
      S_MULC: begin
        cmd.mul_c  = 1'b1;
        state_next = S_CSTART;
      end
      S_CSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_coef  = 1'b1;
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        if (stat.div_done) begin
          cmd.take_c = 1'b1;
          state_next = S_MULH;
        end
      end
      S_MULH: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MULL;
      end
      S_MULL: begin
        cmd.mul_lo = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        if (k == nbi_pkg::KW'(POINTS - 1)) begin
          state_next = S_FIN;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_DIFF;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      done  <= (state == S_FIN);
    end
  end

endmodule

>>> src/nbi_dp.sv
// ----------------------------------------------------------------------------
// nbi_dp: interpolator datapath
// Sample table, config registers, difference lanes, shared multiplier,
// shared divider and the saturating accumulator.
// ----------------------------------------------------------------------------
module nbi_dp #(
  parameter int POINTS = nbi_pkg::POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nbi_pkg::nbi_cmd_t            cmd,
  output nbi_pkg::nbi_stat_t           stat,
  input  logic [2:0]                  sample_index,
  input  logic signed [31:0]          sample_value,
  input  logic signed [31:0]          query_x,
  input  logic                        cfg_valid,
  input  logic [nbi_pkg::CIW-1:0]     cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic signed [31:0]          interpolated,
  output logic                        overflow
);

  localparam int DIFW = 32 + POINTS;
  localparam int IW   = $clog2(POINTS);
  localparam int NUMW = nbi_pkg::NUMW;
  localparam int DVW  = nbi_pkg::DVW;
  localparam int HW   = nbi_pkg::HW;

  logic signed [31:0]     first_abs;
  logic [HW-1:0]          spacing;
  logic signed [31:0]     samples [POINTS];
  logic signed [DIFW-1:0] d [POINTS];
  logic signed [31:0]     x;
  logic signed [NUMW-1:0] num;
  logic signed [31:0]     s;
  logic signed [32:0]     fac;
  logic [HW-1:0]          c_mag;
  logic                   c_neg;
  logic [63:0]            prod;
  logic [63:0]            hi;
  logic signed [62:0]     acc;
  logic                   ovf;

  logic [HW-1:0]          h;
  logic [NUMW-1:0]        hp;
  logic signed [NUMW-1:0] num_w;
  logic                   num_neg;
  logic [NUMW-1:0]        num_mag;
  logic                   fac_neg;
  logic [32:0]            fac_abs;
  logic [IW-1:0]          didx;
  logic signed [DIFW-1:0] dsel;
  logic [DIFW-1:0]        dm;
  logic [31:0]            ma, mb;
  logic [DVW-1:0]         div_a;
  logic [HW-1:0]          div_b;
  logic                   div_done;
  logic [DVW-1:0]         div_q;
  logic                   q_big;
  logic [HW-1:0]          q_sat;
  logic [63:0]            m;
  logic                   tneg;
  logic signed [65:0]     tval, sum;

  assign h       = (spacing == '0) ? HW'(1) : spacing;
  assign hp      = NUMW'(h) * NUMW'(POINTS - 1);
  assign num_w   = NUMW'(x) - NUMW'(first_abs) - $signed(hp);
  assign num_neg = num[NUMW-1];
  assign num_mag = num_neg ? NUMW'(-num) : NUMW'(num);
  assign fac_neg = fac[32];
  assign fac_abs = fac_neg ? 33'(-fac) : 33'(fac);
  assign didx    = IW'(POINTS - 1 - int'(cmd.k));
  assign dsel    = d[didx];
  assign dm      = dsel[DIFW-1] ? DIFW'(-dsel) : DIFW'(dsel);

  // dividend is |num| scaled by 2^16 or the coefficient product over 2^16
  assign div_a = cmd.div_coef ? DVW'(prod[63:16]) : {num_mag[DVW-17:0], 16'h0000};
  assign div_b = cmd.div_coef ? HW'(cmd.k) : h;

  assign q_big = div_q > DVW'(nbi_pkg::C_MAX);
  assign q_sat = q_big ? nbi_pkg::C_MAX : div_q[HW-1:0];

  assign stat.div_done = div_done;

  nbi_div #(.DVW(DVW), .DSW(HW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    ma = '0;
    mb = '0;
    priority if (cmd.mul_c) begin
      ma = {1'b0, c_mag};
      mb = fac_abs[31:0];
    end else if (cmd.mul_hi) begin
      ma = 32'(dm[DIFW-1:16]);
      mb = {1'b0, c_mag};
    end else if (cmd.mul_lo) begin
      ma = {16'h0000, dm[15:0]};
      mb = {1'b0, c_mag};
    end
  end

  // term = (|d| >> 16) * |c| + ((|d| & 0xffff) * |c|) >> 16
  assign m    = hi + (prod >> 16);
  assign tneg = dsel[DIFW-1] ^ c_neg;
  assign tval = tneg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  assign sum  = 66'(acc) + tval;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_abs <= nbi_pkg::FIRST_RST;
      spacing   <= nbi_pkg::SPACING_RST;
      for (int i = 0; i < POINTS; i++) begin
        samples[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == nbi_pkg::REG_FIRST) begin
          first_abs <= cfg_data;
        end else if (cfg_index == nbi_pkg::REG_SPACING) begin
          spacing <= cfg_data[HW-1:0];
        end
      end
      for (int i = 0; i < POINTS; i++) begin
        if (cmd.load_wr && (32'(sample_index) == i)) begin
          samples[i] <= sample_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_go) begin
      x   <= query_x;
      ovf <= 1'b0;
      for (int i = 0; i < POINTS; i++) begin
        d[i] <= DIFW'(samples[i]);
      end
    end
    if (cmd.calc_num) begin
      num <= num_w;
    end
    if (cmd.take_s) begin
      s     <= num_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      c_mag <= nbi_pkg::ONE_Q;
      c_neg <= 1'b0;
      acc   <= 63'(d[POINTS-1]);
      if (q_big) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.diff) begin
      for (int i = 0; i < POINTS - 1; i++) begin
        if (i < POINTS - int'(cmd.k)) begin
          d[i] <= d[i+1] - d[i];
        end
      end
      fac <= 33'(s) + $signed({1'b0, nbi_pkg::KW'(cmd.k - 1'b1), 16'h0000});
    end
    if (cmd.mul_c || cmd.mul_hi || cmd.mul_lo) begin
      prod <= ma * mb;
    end
    if (cmd.mul_lo) begin
      hi <= prod;
    end
    if (cmd.take_c) begin
      c_mag <= q_sat;
      c_neg <= c_neg ^ fac_neg;
      if (q_big) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.acc_step) begin
      if (sum > 66'(nbi_pkg::ACC_MAX)) begin
        acc <= nbi_pkg::ACC_MAX;
        ovf <= 1'b1;
      end else if (sum < -66'(nbi_pkg::ACC_MAX)) begin
        acc <= -nbi_pkg::ACC_MAX;
        ovf <= 1'b1;
      end else begin
        acc <= sum[62:0];
      end
    end
    if (cmd.fin) begin
      if (acc > 63'sd2147483647) begin
        interpolated <= 32'sh7fffffff;
        overflow     <= 1'b1;
      end else if (acc < -63'sd2147483648) begin
        interpolated <= 32'sh80000000;
        overflow     <= 1'b1;
      end else begin
        interpolated <= acc[31:0];
        overflow     <= ovf;
      end
    end
  end

endmodule

>>> src/nbi_checker.sv
// ----------------------------------------------------------------------------
// nbi_checker: port-level checks
// Handshake and sequencing properties seen on the top-level ports.
// ----------------------------------------------------------------------------
module nbi_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic mode,
  input logic done
);

  // a query transfer always starts work
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode |=> busy)
    else $error("query did not raise busy");

  // a load transfer leaves the block free and gives no result
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !mode |=> !busy && !done)
    else $error("load stalled the block or made a result");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held past one cycle");

  // a result comes only once work is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finished query");

endmodule

bind newton_backward_interpolator nbi_checker u_nbi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .mode  (mode),
  .done  (done)
);
